// ===== rtl/svrd_pkg.sv =====
`timescale 1ns / 1ps
// svrd_pkg: shared types, record codes and the colour ROM of the slide decoder.
// No dependencies.
package svrd_pkg;

	typedef enum logic [2:0] {
		KIND_LINE   = 3'd0,
		KIND_COLOUR = 3'd1,
		KIND_WINDOW = 3'd2,
		KIND_END    = 3'd3,
		KIND_BAD    = 3'd4
	} kind_t;

	localparam logic [7:0] TYPE_ABS_MAX = 8'h7F;
	localparam logic [7:0] TYPE_OFFSET  = 8'hFB;
	localparam logic [7:0] TYPE_END     = 8'hFC;
	localparam logic [7:0] TYPE_FILL    = 8'hFD;
	localparam logic [7:0] TYPE_COMMON  = 8'hFE;
	localparam logic [7:0] TYPE_COLOUR  = 8'hFF;

	// header bytes holding the window size words
	localparam int WIN_FIRST = 19;
	localparam int WIN_LAST  = 22;

	localparam int REC_BYTES = 8;
	localparam int REC_IDX_W = 3;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ex;
		logic [15:0] ey;
		logic [3:0]  pen;
		logic [15:0] w;
		logic [15:0] h;
	} result_t;

	function automatic logic [3:0] rec_len(input logic [7:0] typ);
		logic [3:0] len;
		if (typ <= TYPE_ABS_MAX) len = 4'd8;
		else if (typ == TYPE_OFFSET) len = 4'd5;
		else if (typ == TYPE_FILL) len = 4'd6;
		else if (typ == TYPE_COMMON) len = 4'd3;
		else len = 4'd2;
		return len;
	endfunction

	function automatic logic [15:0] add_off(input logic [15:0] base, input logic [7:0] off);
		return base + {{8{off[7]}}, off};
	endfunction

	function automatic logic [3:0] colour_of(input logic [7:0] idx);
		logic [3:0] c;
		if (idx < 8'd10) begin
			unique case (idx[3:0])
				4'd0: c = 4'd0;
				4'd1: c = 4'd4;
				4'd2: c = 4'd14;
				4'd3: c = 4'd2;
				4'd4: c = 4'd3;
				4'd5: c = 4'd1;
				4'd6: c = 4'd5;
				4'd7: c = 4'd15;
				4'd8: c = 4'd8;
				4'd9: c = 4'd7;
				default: c = 4'd0;
			endcase
		end
		else if (idx < 8'd30) c = 4'd4;
		else if (idx < 8'd50) c = 4'd6;
		else if (idx < 8'd70) c = 4'd14;
		else if (idx < 8'd100) c = 4'd2;
		else if (idx < 8'd140) c = 4'd3;
		else if (idx < 8'd210) c = 4'd1;
		else if (idx < 8'd240) c = 4'd13;
		else if (idx < 8'd250) c = 4'd4;
		else if (idx < 8'd253) c = 4'd8;
		else c = 4'd7;
		return c;
	endfunction

endpackage

// ===== rtl/svrd_in_reg.sv =====
`timescale 1ns / 1ps
// svrd_in_reg: input beat register of the slide decoder.
// Depends on nothing; free comes from the result register.
module svrd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       start_of_file,
	input  logic       free,
	output logic       advance,
	output logic [7:0] data_s1,
	output logic       sof_s1
);

	logic valid_s1;

	assign advance  = valid_s1 & free;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
	end

endmodule

// ===== rtl/svrd_decode.sv =====
`timescale 1ns / 1ps
// svrd_decode: header/record parser state and per-beat command decode.
// Depends on svrd_pkg.
module svrd_decode #(
	parameter int HEADER_BYTES = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           data_s1,
	input  logic                 sof_s1,
	output svrd_pkg::result_t    res
);

	localparam int CNT_W = $clog2(HEADER_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_RECORD,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_e, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_e, cnt_d, cnt_inc;
	logic [15:0] last_x_q, last_y_q, last_x_e, last_y_e, last_x_d, last_y_d;
	logic [15:0] prev_x_q, prev_y_q, prev_x_e, prev_y_e, prev_x_d, prev_y_d;
	logic [15:0] first_x_q, first_y_q, first_x_e, first_y_e, first_x_d, first_y_d;
	logic        idle_q, idle_e, idle_d;

	logic [7:0]  rb_q [svrd_pkg::REC_BYTES];
	logic [7:0]  rb_n [svrd_pkg::REC_BYTES];
	logic        wr_en;
	logic [svrd_pkg::REC_IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] win_off;

	logic [7:0]  typ;
	logic [15:0] fx, fy, nx, ny;

	// restart folds in ahead of the decode
	always_comb begin
		phase_e   = sof_s1 ? PH_HEADER : phase_q;
		cnt_e     = sof_s1 ? '0 : cnt_q;
		last_x_e  = sof_s1 ? '0 : last_x_q;
		last_y_e  = sof_s1 ? '0 : last_y_q;
		prev_x_e  = sof_s1 ? '0 : prev_x_q;
		prev_y_e  = sof_s1 ? '0 : prev_y_q;
		first_x_e = sof_s1 ? '0 : first_x_q;
		first_y_e = sof_s1 ? '0 : first_y_q;
		idle_e    = sof_s1 ? 1'b1 : idle_q;
	end

	assign cnt_inc = cnt_e + CNT_W'(1);
	assign win_off = cnt_e - CNT_W'(svrd_pkg::WIN_FIRST);

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = '0;
		unique case (phase_e)
			PH_HEADER: begin
				if (cnt_e >= CNT_W'(svrd_pkg::WIN_FIRST) &&
				    cnt_e <= CNT_W'(svrd_pkg::WIN_LAST)) begin
					wr_en  = 1'b1;
					wr_idx = win_off[svrd_pkg::REC_IDX_W-1:0];
				end
			end
			PH_RECORD: begin
				wr_en  = 1'b1;
				wr_idx = cnt_e[svrd_pkg::REC_IDX_W-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < svrd_pkg::REC_BYTES; i++) begin
			rb_n[i] = (wr_en && wr_idx == svrd_pkg::REC_IDX_W'(i)) ? data_s1 : rb_q[i];
		end
	end

	assign typ = rb_n[1];
	assign fx  = {rb_n[3], rb_n[2]};
	assign fy  = {rb_n[5], rb_n[4]};
	assign nx  = svrd_pkg::add_off(last_x_e, rb_n[0]);
	assign ny  = svrd_pkg::add_off(last_y_e, rb_n[2]);

	always_comb begin
		phase_d   = phase_e;
		cnt_d     = cnt_e;
		last_x_d  = last_x_e;
		last_y_d  = last_y_e;
		prev_x_d  = prev_x_e;
		prev_y_d  = prev_y_e;
		first_x_d = first_x_e;
		first_y_d = first_y_e;
		idle_d    = idle_e;
		res       = '0;
		unique case (phase_e)
			PH_HEADER: begin
				if (cnt_e == CNT_W'(HEADER_BYTES - 1)) begin
					phase_d   = PH_RECORD;
					cnt_d     = '0;
					res.valid = 1'b1;
					res.kind  = svrd_pkg::KIND_WINDOW;
					res.w     = {rb_n[1], rb_n[0]};
					res.h     = {rb_n[3], rb_n[2]};
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_RECORD: begin
				if (cnt_inc >= CNT_W'(2) &&
				    cnt_inc >= CNT_W'(svrd_pkg::rec_len(typ))) begin
					cnt_d     = '0;
					res.valid = 1'b1;
					res.kind  = svrd_pkg::KIND_LINE;
					priority if (typ <= svrd_pkg::TYPE_ABS_MAX) begin
						res.sx   = {rb_n[1], rb_n[0]};
						res.sy   = {rb_n[3], rb_n[2]};
						res.ex   = {rb_n[5], rb_n[4]};
						res.ey   = {rb_n[7], rb_n[6]};
						last_x_d = {rb_n[1], rb_n[0]};
						last_y_d = {rb_n[3], rb_n[2]};
					end else if (typ == svrd_pkg::TYPE_OFFSET) begin
						res.sx   = nx;
						res.sy   = ny;
						res.ex   = svrd_pkg::add_off(last_x_e, rb_n[3]);
						res.ey   = svrd_pkg::add_off(last_y_e, rb_n[4]);
						last_x_d = nx;
						last_y_d = ny;
					end else if (typ == svrd_pkg::TYPE_END) begin
						res.kind = svrd_pkg::KIND_END;
						phase_d  = PH_DONE;
					end else if (typ == svrd_pkg::TYPE_FILL) begin
						if (fy[15]) begin
							if (!idle_e) begin
								idle_d = 1'b1;
								res.sx = prev_x_e;
								res.sy = prev_y_e;
								res.ex = first_x_e;
								res.ey = first_y_e;
							end else begin
								res.valid = 1'b0;
							end
						end else if (idle_e) begin
							first_x_d = fx;
							first_y_d = fy;
							prev_x_d  = fx;
							prev_y_d  = fy;
							idle_d    = 1'b0;
							res.valid = 1'b0;
						end else begin
							res.sx   = prev_x_e;
							res.sy   = prev_y_e;
							res.ex   = fx;
							res.ey   = fy;
							prev_x_d = fx;
							prev_y_d = fy;
						end
					end else if (typ == svrd_pkg::TYPE_COMMON) begin
						res.sx   = last_x_e;
						res.sy   = last_y_e;
						res.ex   = nx;
						res.ey   = ny;
						last_x_d = nx;
						last_y_d = ny;
					end else if (typ == svrd_pkg::TYPE_COLOUR) begin
						res.kind = svrd_pkg::KIND_COLOUR;
						res.pen  = svrd_pkg::colour_of(rb_n[0]);
					end else begin
						res.kind = svrd_pkg::KIND_BAD;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			cnt_q     <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			idle_q    <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			last_x_q  <= last_x_d;
			last_y_q  <= last_y_d;
			prev_x_q  <= prev_x_d;
			prev_y_q  <= prev_y_d;
			first_x_q <= first_x_d;
			first_y_q <= first_y_d;
			idle_q    <= idle_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			rb_q[wr_idx] <= data_s1;
		end
	end

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !sof_s1) |-> !res.valid)
		else $error("result decoded after end record");

	a_rec_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECORD) |-> (cnt_q < CNT_W'(svrd_pkg::REC_BYTES)))
		else $error("record byte count out of range");

	a_window_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == svrd_pkg::KIND_WINDOW) |-> (phase_e == PH_HEADER))
		else $error("window size outside header");

	a_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid && res.kind == svrd_pkg::KIND_END) |=> (phase_q == PH_DONE))
		else $error("end record did not stop decoding");

endmodule

// ===== rtl/svrd_out_reg.sv =====
`timescale 1ns / 1ps
// svrd_out_reg: result register driving the command output channel.
// Depends on svrd_pkg.
module svrd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  svrd_pkg::result_t  res,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic signed [15:0] start_x,
	output logic signed [15:0] start_y,
	output logic signed [15:0] end_x,
	output logic signed [15:0] end_y,
	output logic [3:0]         pen_colour,
	output logic [15:0]        window_width,
	output logic [15:0]        window_height
);

	svrd_pkg::result_t res_s2;
	logic              valid_s2;
	logic              load;

	assign free = ~valid_s2 | out_ready;
	assign load = advance & res.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = res_s2.kind;
	assign start_x       = $signed(res_s2.sx);
	assign start_y       = $signed(res_s2.sy);
	assign end_x         = $signed(res_s2.ex);
	assign end_y         = $signed(res_s2.ey);
	assign pen_colour    = res_s2.pen;
	assign window_width  = res_s2.w;
	assign window_height = res_s2.h;

endmodule

// ===== rtl/slide_vector_record_decoder.sv =====
`timescale 1ns / 1ps
// slide_vector_record_decoder: byte-stream slide file decoder, top level.
// An accepted byte is registered in svrd_in_reg, and its command in svrd_out_reg.
// Throughput: one byte per cycle; the input register stalls only while a
// command waits in the output register with out_ready low.
// Reset (arst_n low, asynchronous): header phase, last point and fill state cleared.
// Depends on svrd_pkg, svrd_in_reg, svrd_decode, svrd_out_reg.
module slide_vector_record_decoder #(
	parameter int HEADER_BYTES = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               start_of_file,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic signed [15:0] start_x,
	output logic signed [15:0] start_y,
	output logic signed [15:0] end_x,
	output logic signed [15:0] end_y,
	output logic [3:0]         pen_colour,
	output logic [15:0]        window_width,
	output logic [15:0]        window_height
);

	logic              free;
	logic              advance;
	logic [7:0]        data_s1;
	logic              sof_s1;
	svrd_pkg::result_t res;

	svrd_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.free          (free),
		.advance       (advance),
		.data_s1       (data_s1),
		.sof_s1        (sof_s1)
	);

	svrd_decode #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data_s1 (data_s1),
		.sof_s1  (sof_s1),
		.res     (res)
	);

	svrd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.res           (res),
		.free          (free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.pen_colour    (pen_colour),
		.window_width  (window_width),
		.window_height (window_height)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

endmodule

// ===== sim/slide_vector_record_decoder_test.sv =====
`timescale 1ns / 1ps
// slide_vector_record_decoder_test: self-checking bench for the slide file decoder.
// Random slide files and untyped directed rows are checked against a behavioral decoder;
// typed directed rows carry their own expected command. Depends on svrd_pkg and slide_vector_record_decoder.
module slide_vector_record_decoder_test;

	localparam int HDR_LEN = 31;

	typedef enum logic [1:0] {PH_HEADER, PH_RECORD, PH_DONE} slide_phase_t;
	typedef enum logic {ROW_HEADER, ROW_BYTES} row_kind_t;

	typedef struct packed {
		svrd_pkg::kind_t kind;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ex;
		logic [15:0] ey;
		logic [3:0]  pen;
		logic [15:0] w;
		logic [15:0] h;
	} cmd_t;

	typedef struct packed {
		row_kind_t   rk;
		logic        sof;
		logic [3:0]  n;
		logic [63:0] by;
		logic        typed;
		logic        has;
		cmd_t        want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic start_of_file = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic signed [15:0] start_x, start_y, end_x, end_y;
	logic [3:0] pen_colour;
	logic [15:0] window_width, window_height;

	cmd_t pending_cmds[$];
	dir_row_t dir_rows[$];
	int mismatches = 0;
	int beats_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic long_stall_req = 1'b0;

	// decoder state
	slide_phase_t ph;
	logic [4:0] cnt;
	logic [7:0] rb [8];
	logic [15:0] lx, ly, fpx, fpy, ffx, ffy;
	logic fill_open;

	slide_vector_record_decoder #(.HEADER_BYTES(HDR_LEN)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .start_of_file(start_of_file),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .pen_colour(pen_colour),
		.window_width(window_width), .window_height(window_height)
	);

	always #5 clk = ~clk;

	function automatic cmd_t line_cmd(input logic [15:0] sx, sy, ex, ey);
		cmd_t c;
		c = '0;
		c.kind = svrd_pkg::KIND_LINE;
		c.sx = sx;
		c.sy = sy;
		c.ex = ex;
		c.ey = ey;
		return c;
	endfunction

	function automatic cmd_t pen_cmd(input logic [3:0] pen);
		cmd_t c;
		c = '0;
		c.kind = svrd_pkg::KIND_COLOUR;
		c.pen = pen;
		return c;
	endfunction

	function automatic cmd_t win_cmd(input logic [15:0] w, h);
		cmd_t c;
		c = '0;
		c.kind = svrd_pkg::KIND_WINDOW;
		c.w = w;
		c.h = h;
		return c;
	endfunction

	function automatic cmd_t bare_cmd(input svrd_pkg::kind_t k);
		cmd_t c;
		c = '0;
		c.kind = k;
		return c;
	endfunction

	function automatic logic [3:0] rom_pen(input logic [7:0] idx);
		logic [3:0] p;
		case (idx)
			8'd0: p = 4'd0;
			8'd1: p = 4'd4;
			8'd2: p = 4'd14;
			8'd3: p = 4'd2;
			8'd4: p = 4'd3;
			8'd5: p = 4'd1;
			8'd6: p = 4'd5;
			8'd7: p = 4'd15;
			8'd8: p = 4'd8;
			8'd9: p = 4'd7;
			default: begin
				if (idx >= 8'd253) p = 4'd7;
				else if (idx >= 8'd250) p = 4'd8;
				else if (idx >= 8'd240) p = 4'd4;
				else if (idx >= 8'd210) p = 4'd13;
				else if (idx >= 8'd140) p = 4'd1;
				else if (idx >= 8'd100) p = 4'd3;
				else if (idx >= 8'd70) p = 4'd2;
				else if (idx >= 8'd50) p = 4'd14;
				else if (idx >= 8'd30) p = 4'd6;
				else p = 4'd4;
			end
		endcase
		return p;
	endfunction

	function automatic logic [15:0] le_word(input int i);
		return {rb[(i + 1) % 8], rb[i % 8]};
	endfunction

	function automatic logic [15:0] step_off(input logic [15:0] base, input logic [7:0] off);
		logic signed [15:0] d;
		d = 16'($signed(off));
		return base + d;
	endfunction

	function automatic int record_size(input logic [7:0] t);
		if (t <= svrd_pkg::TYPE_ABS_MAX) return 8;
		case (t)
			svrd_pkg::TYPE_OFFSET: return 5;
			svrd_pkg::TYPE_FILL:   return 6;
			svrd_pkg::TYPE_COMMON: return 3;
			default:               return 2;
		endcase
	endfunction

	task automatic clear_decoder();
		ph = PH_HEADER;
		cnt = '0;
		for (int i = 0; i < 8; i++) rb[i] = 8'd0;
		lx = '0; ly = '0;
		fpx = '0; fpy = '0; ffx = '0; ffy = '0;
		fill_open = 1'b0;
	endtask

	task automatic finish_record(output logic has, output cmd_t c);
		logic [15:0] x, y, px, py;
		has = 1'b1;
		c = '0;
		if (rb[1] <= svrd_pkg::TYPE_ABS_MAX) begin
			lx = le_word(0);
			ly = le_word(2);
			c = line_cmd(lx, ly, le_word(4), le_word(6));
		end else begin
			case (rb[1])
				svrd_pkg::TYPE_OFFSET: begin
					x = step_off(lx, rb[0]);
					y = step_off(ly, rb[2]);
					c = line_cmd(x, y, step_off(lx, rb[3]), step_off(ly, rb[4]));
					lx = x;
					ly = y;
				end
				svrd_pkg::TYPE_END: begin
					ph = PH_DONE;
					c = bare_cmd(svrd_pkg::KIND_END);
				end
				svrd_pkg::TYPE_FILL: begin
					x = le_word(2);
					y = le_word(4);
					if (y[15]) begin
						has = fill_open;
						if (fill_open) c = line_cmd(fpx, fpy, ffx, ffy);
						fill_open = 1'b0;
					end else if (!fill_open) begin
						ffx = x; ffy = y; fpx = x; fpy = y;
						fill_open = 1'b1;
						has = 1'b0;
					end else begin
						px = fpx;
						py = fpy;
						fpx = x;
						fpy = y;
						c = line_cmd(px, py, x, y);
					end
				end
				svrd_pkg::TYPE_COMMON: begin
					px = lx;
					py = ly;
					lx = step_off(lx, rb[0]);
					ly = step_off(ly, rb[2]);
					c = line_cmd(px, py, lx, ly);
				end
				svrd_pkg::TYPE_COLOUR: c = pen_cmd(rom_pen(rb[0]));
				default: c = bare_cmd(svrd_pkg::KIND_BAD);
			endcase
		end
	endtask

	task automatic decode_beat(input logic [7:0] b, input logic sof, output logic has,
			output cmd_t c);
		has = 1'b0;
		c = '0;
		if (sof) clear_decoder();
		if (ph == PH_DONE) return;
		if (ph == PH_HEADER) begin
			if (cnt >= 5'd19 && cnt <= 5'd22) rb[3'(cnt - 5'd19)] = b;
			if (int'(cnt) == HDR_LEN - 1) begin
				ph = PH_RECORD;
				cnt = '0;
				has = 1'b1;
				c = win_cmd(le_word(0), le_word(2));
			end else begin
				cnt = cnt + 5'd1;
			end
			return;
		end
		rb[cnt[2:0]] = b;
		cnt = cnt + 5'd1;
		if (cnt >= 5'd2 && int'(cnt) >= record_size(rb[1])) begin
			cnt = '0;
			finish_record(has, c);
		end
	endtask

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(input logic [7:0] b, input logic sof, input logic typed,
			input logic has, input cmd_t want);
		logic got;
		cmd_t c;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		start_of_file = sof;
		do @(posedge clk); while (!in_ready);
		decode_beat(b, sof, got, c);
		if (typed) begin
			got = has;
			c = want;
		end
		if (got) pending_cmds.push_back(c);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes(input logic [63:0] by, input int n, input logic sof,
			input logic typed, input logic has, input cmd_t want);
		for (int i = 0; i < n; i++)
			send_beat(by[8*i +: 8], sof && i == 0, typed && i == n - 1, has, want);
	endtask

	task automatic send_header(input logic sof, input logic [15:0] w, h, input logic typed,
			input logic has, input cmd_t want);
		logic [7:0] b;
		for (int i = 0; i < HDR_LEN; i++) begin
			case (i)
				19: b = w[7:0];
				20: b = w[15:8];
				21: b = h[7:0];
				22: b = h[15:8];
				default: b = 8'($urandom);
			endcase
			send_beat(b, sof && i == 0, typed && i == HDR_LEN - 1, has, want);
		end
	endtask

	task automatic make_record(output logic [63:0] by, output int n);
		int r;
		r = $urandom_range(0, 99);
		by = {$urandom, $urandom};
		if (r < 28) begin
			by[15:8] = 8'($urandom_range(0, 127));
			n = 8;
		end else if (r < 42) begin
			by[15:8] = svrd_pkg::TYPE_OFFSET;
			n = 5;
		end else if (r < 56) begin
			by[15:8] = svrd_pkg::TYPE_COMMON;
			n = 3;
		end else if (r < 74) begin
			by[15:8] = svrd_pkg::TYPE_FILL;
			by[47] = ($urandom_range(0, 9) < 3);
			n = 6;
		end else if (r < 88) begin
			by[15:8] = svrd_pkg::TYPE_COLOUR;
			n = 2;
		end else if (r < 96) begin
			by[15:8] = 8'($urandom_range(8'h80, 8'hFA));
			n = 2;
		end else begin
			n = $urandom_range(1, 3);
		end
	endtask

	task automatic random_slide();
		logic [63:0] by;
		int n;
		int r;
		if ($urandom_range(0, 19) == 0)
			send_bytes({$urandom, $urandom}, $urandom_range(1, 8), 1'b1, 1'b0, 1'b0, '0);
		send_header(1'b1, 16'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
		repeat ($urandom_range(4, 40)) begin
			make_record(by, n);
			send_bytes(by, n, 1'b0, 1'b0, 1'b0, '0);
		end
		r = $urandom_range(0, 9);
		if (r < 7) begin
			send_bytes({48'd0, svrd_pkg::TYPE_END, 8'h00}, 2, 1'b0, 1'b0, 1'b0, '0);
			repeat ($urandom_range(0, 4)) send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
		end else if (r < 9) begin
			make_record(by, n);
			if (n > 1) send_bytes(by, $urandom_range(1, n - 1), 1'b0, 1'b0, 1'b0, '0);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
	endtask

	function automatic dir_row_t hdr_row(input logic sof, input logic [15:0] w, h);
		dir_row_t r;
		r = '0;
		r.rk = ROW_HEADER;
		r.sof = sof;
		r.by = {32'd0, h, w};
		r.typed = 1'b1;
		r.has = 1'b1;
		r.want = win_cmd(w, h);
		return r;
	endfunction

	function automatic dir_row_t rec_row(input logic sof, input int n, input logic [63:0] by,
			input logic typed, input logic has, input cmd_t want);
		dir_row_t r;
		r = '0;
		r.rk = ROW_BYTES;
		r.sof = sof;
		r.n = 4'(n);
		r.by = by;
		r.typed = typed;
		r.has = has;
		r.want = want;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		cmd_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected command, expected none actual kind %0d",
					$time, kind);
			end else begin
				want = pending_cmds.pop_front();
				check_field("kind", 16'(want.kind), 16'(kind));
				check_field("start_x", want.sx, start_x);
				check_field("start_y", want.sy, start_y);
				check_field("end_x", want.ex, end_x);
				check_field("end_y", want.ey, end_y);
				check_field("pen_colour", 16'(want.pen), 16'(pen_colour));
				check_field("window_width", want.w, window_width);
				check_field("window_height", want.h, window_height);
			end
		end
	end

	// output side: random back-pressure, plus one long hold-off on request
	initial begin : rx_side
		logic stall_taken;
		stall_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_req && !stall_taken) begin
				out_ready = 1'b0;
				stall_taken = 1'b1;
				repeat (300) @(negedge clk);
			end else begin
				out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		clear_decoder();
		dir_rows.push_back(hdr_row(1'b0, 16'hFFFF, 16'h0000));
		dir_rows.push_back(rec_row(1'b0, 8, {16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF}, 1'b1,
			1'b1, line_cmd(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF)));
		dir_rows.push_back(rec_row(1'b0, 8, {16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000}, 1'b1,
			1'b1, line_cmd(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF)));
		dir_rows.push_back(rec_row(1'b0, 5,
			{24'd0, 8'h01, 8'hFF, 8'h80, svrd_pkg::TYPE_OFFSET, 8'h7F}, 1'b0, 1'b0, '0));
		dir_rows.push_back(rec_row(1'b0, 3, {40'd0, 8'h7F, svrd_pkg::TYPE_COMMON, 8'h80},
			1'b0, 1'b0, '0));
		dir_rows.push_back(rec_row(1'b0, 8, {16'h5678, 16'h1234, 16'hFFF0, 16'h7F00}, 1'b1,
			1'b1, line_cmd(16'h7F00, 16'hFFF0, 16'h1234, 16'h5678)));
		dir_rows.push_back(rec_row(1'b0, 3, {40'd0, 8'h7F, svrd_pkg::TYPE_COMMON, 8'h7F},
			1'b0, 1'b0, '0));
		dir_rows.push_back(rec_row(1'b0, 2, {48'd0, svrd_pkg::TYPE_COLOUR, 8'h00}, 1'b1, 1'b1,
			pen_cmd(4'd0)));
		dir_rows.push_back(rec_row(1'b0, 2, {48'd0, svrd_pkg::TYPE_COLOUR, 8'hFF}, 1'b1, 1'b1,
			pen_cmd(4'd7)));
		dir_rows.push_back(rec_row(1'b0, 2, {48'd0, svrd_pkg::TYPE_COLOUR, 8'd210}, 1'b1, 1'b1,
			pen_cmd(4'd13)));
		dir_rows.push_back(rec_row(1'b0, 2, {48'd0, 8'h80, 8'h12}, 1'b1, 1'b1,
			bare_cmd(svrd_pkg::KIND_BAD)));
		dir_rows.push_back(rec_row(1'b0, 2, {48'd0, 8'hFA, 8'h34}, 1'b1, 1'b1,
			bare_cmd(svrd_pkg::KIND_BAD)));
		// fill: close with no polygon open, open, add a point, close
		dir_rows.push_back(rec_row(1'b0, 6,
			{16'd0, 16'h8000, 16'h1111, svrd_pkg::TYPE_FILL, 8'hAB}, 1'b1, 1'b0, '0));
		dir_rows.push_back(rec_row(1'b0, 6,
			{16'd0, 16'h7FFF, 16'hFFFF, svrd_pkg::TYPE_FILL, 8'h00}, 1'b1, 1'b0, '0));
		dir_rows.push_back(rec_row(1'b0, 6,
			{16'd0, 16'h0000, 16'h8000, svrd_pkg::TYPE_FILL, 8'hFF}, 1'b1, 1'b1,
			line_cmd(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000)));
		dir_rows.push_back(rec_row(1'b0, 6,
			{16'd0, 16'hFFFF, 16'h0000, svrd_pkg::TYPE_FILL, 8'h00}, 1'b1, 1'b1,
			line_cmd(16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF)));
		dir_rows.push_back(rec_row(1'b0, 2, {48'd0, svrd_pkg::TYPE_END, 8'h00}, 1'b1, 1'b1,
			bare_cmd(svrd_pkg::KIND_END)));
		dir_rows.push_back(rec_row(1'b0, 8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0));
		dir_rows.push_back(hdr_row(1'b1, 16'h8001, 16'hFFFF));
		dir_rows.push_back(rec_row(1'b0, 3, {40'd0, 8'h55, 8'h12, 8'h34}, 1'b0, 1'b0, '0));
		dir_rows.push_back(hdr_row(1'b1, 16'h0000, 16'h7FFF));
		dir_rows.push_back(rec_row(1'b0, 3, {40'd0, 8'h01, svrd_pkg::TYPE_COMMON, 8'h01},
			1'b1, 1'b1, line_cmd(16'h0000, 16'h0000, 16'h0001, 16'h0001)));
		dir_rows.push_back(rec_row(1'b1, 5, 64'h0000_00A5_5A00_FF00, 1'b0, 1'b0, '0));
		dir_rows.push_back(hdr_row(1'b1, 16'h00FF, 16'hFF00));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 18;
		rx_idle_pct = 72;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].rk == ROW_HEADER)
				send_header(dir_rows[i].sof, dir_rows[i].by[15:0], dir_rows[i].by[31:16],
					dir_rows[i].typed, dir_rows[i].has, dir_rows[i].want);
			else
				send_bytes(dir_rows[i].by, int'(dir_rows[i].n), dir_rows[i].sof,
					dir_rows[i].typed, dir_rows[i].has, dir_rows[i].want);
		end
		drain();

		for (int p = 0; p < 3; p++) begin
			int goal;
			goal = beats_sent + 500;
			tx_idle_pct = (p == 0) ? 18 : (p == 1) ? 72 : 0;
			rx_idle_pct = (p == 0) ? 72 : (p == 1) ? 18 : 0;
			if (p == 2) long_stall_req = 1'b1;
			while (beats_sent < goal) random_slide();
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/svrd_pkg.sv
rtl/svrd_in_reg.sv
rtl/svrd_decode.sv
rtl/svrd_out_reg.sv
rtl/slide_vector_record_decoder.sv
sim/slide_vector_record_decoder_test.sv
